/* sv/ntc_beta_temperature_converter_unit_defines.svh */
// ----------------------------------------------------------------------------
// NTC converter assertion macros
// Shared property forms for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef NTC_BETA_TEMPERATURE_CONVERTER_UNIT_DEFINES_SVH
`define NTC_BETA_TEMPERATURE_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NTCBC_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NTCBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ntcbc_pkg.sv */
// ----------------------------------------------------------------------------
// NTC converter package
// Types and constants shared by the converter pipeline.
// ----------------------------------------------------------------------------
package ntcbc_pkg;

   localparam logic [12:0] BETA_RESET  = 13'd3950;
   localparam logic [9:0]  CODE_FULL   = 10'd1023;
   // 1025 * 2^16, dividend of the ratio divider
   localparam logic [26:0] RATIO_NUM   = 27'd67174400;
   localparam logic [26:0] RATIO_ONE   = 27'd65536;
   // beta * 2^24 / 298 = beta * 56299 + beta * 114 / 298
   localparam logic [15:0] B298_INT    = 16'd56299;
   localparam logic [6:0]  B298_REM    = 7'd114;
   // ceil(2^28 / 298), exact for the 20-bit numerator range
   localparam logic [19:0] B298_RECIP  = 20'd900791;
   localparam logic [31:0] LN2_Q32     = 32'hB17217F8;
   // 14 - normalization shift gives the integer part of log2
   localparam logic [5:0]  LOG_BIAS    = 6'd14;
   localparam logic signed [22:0] ZERO_C_Q10 = 23'sd279552;
   localparam logic signed [10:0] T_MAX = 11'sd1023;
   localparam logic signed [10:0] T_MIN = -11'sd273;
   localparam logic [12:0] T_MAX_MAG   = 13'd1023;

   typedef struct packed {
      logic        vld;
      logic        zero;
      logic [12:0] beta;
      logic [28:0] b298;
   } tag_type;

endpackage

/* sv/ntcbc_ln_pipe.sv */
// ----------------------------------------------------------------------------
// NTC converter natural log pipeline
// Normalizes the Q16.16 ratio, squares out 24 bits of log2, scales by ln 2.
// ----------------------------------------------------------------------------
module ntcbc_ln_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  ntcbc_pkg::tag_type tag_in,
   input  logic [26:0]        ratio_in,
   output ntcbc_pkg::tag_type tag_out,
   output logic               ln_neg,
   output logic [28:0]        ln_mag
);

   ntcbc_pkg::tag_type tg_ff [0:31];

   logic [30:0] nv_ff  [0:4];
   logic [4:0]  ns_ff  [0:4];
   logic [30:0] sqm_ff [0:24];
   logic [23:0] sfr_ff [0:24];
   logic [4:0]  ssh_ff [0:24];

   logic [28:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [28:0] lnm_ff;
   logic        lnn_ff;
   logic [60:0] ln_prod;
   logic [29:0] lg;

   function automatic logic [5:0] LOG_BIAS_SUB(input logic [4:0] sh);
      return ntcbc_pkg::LOG_BIAS - {1'b0, sh};
   endfunction

   // tag shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         tg_ff[0].vld <= 1'b0;
      end else if (adv) begin
         tg_ff[0] <= tag_in;
      end
   end

   for (genvar i = 0; i < 31; i++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            tg_ff[i+1].vld <= 1'b0;
         end else if (adv) begin
            tg_ff[i+1] <= tg_ff[i];
         end
      end
   end

   // normalization: top set bit moved to bit 30
   always_ff @(posedge clock) begin
      if (adv) begin
         nv_ff[0] <= {4'b0, ratio_in};
         ns_ff[0] <= 5'd0;
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_norm
      localparam int AMT = 16 >> j;
      logic [30:0] v_in;
      logic [4:0]  s_in;
      always_comb begin
         if (nv_ff[j][30 -: AMT] == '0) begin
            v_in = nv_ff[j] << AMT;
            s_in = ns_ff[j] + 5'(AMT);
         end else begin
            v_in = nv_ff[j];
            s_in = ns_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            nv_ff[j+1] <= v_in;
            ns_ff[j+1] <= s_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqm_ff[0] <= nv_ff[4][30] ? nv_ff[4] : (nv_ff[4] << 1);
         ssh_ff[0] <= nv_ff[4][30] ? ns_ff[4] : (ns_ff[4] + 5'd1);
         sfr_ff[0] <= '0;
      end
   end

   // one fraction bit of log2 per square
   for (genvar k = 0; k < 24; k++) begin : g_sq
      logic [61:0] prod;
      logic [31:0] sq;
      logic [30:0] m_in;
      logic [23:0] f_in;
      always_comb begin
         prod = 62'(sqm_ff[k]) * 62'(sqm_ff[k]);
         sq   = prod[61:30];
         if (sq[31]) begin
            m_in = sq[31:1];
            f_in = {sfr_ff[k][22:0], 1'b1};
         end else begin
            m_in = sq[30:0];
            f_in = {sfr_ff[k][22:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sqm_ff[k+1] <= m_in;
            sfr_ff[k+1] <= f_in;
            ssh_ff[k+1] <= ssh_ff[k];
         end
      end
   end

   // signed Q.24 log2, then magnitude
   always_comb begin
      lg     = {LOG_BIAS_SUB(ssh_ff[24]), sfr_ff[24]};
      neg_in = lg[29];
      mag_in = neg_in ? 29'(~lg + 30'd1) : lg[28:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign ln_prod = 61'(mag_ff) * 61'(ntcbc_pkg::LN2_Q32);

   always_ff @(posedge clock) begin
      if (adv) begin
         lnm_ff <= ln_prod[60:32];
         lnn_ff <= neg_ff;
      end
   end

   assign tag_out = tg_ff[31];
   assign ln_neg  = lnn_ff;
   assign ln_mag  = lnm_ff;

endmodule

/* sv/ntc_beta_temperature_converter_unit.sv */
// ----------------------------------------------------------------------------
// NTC beta temperature converter
// Converts a 10-bit thermistor divider reading to whole degrees Celsius.
// ----------------------------------------------------------------------------
// Fully pipelined beta-equation converter: one request per cycle in, one
// response per request out, in order, through 84 register stages. Depth is
// set by three bit-serial chains laid out as stages: the 27-step ratio
// divider (1025/a), the 5-step normalizer plus 24 squaring stages of the
// log2 unit, and a 21-step quotient divider. The whole pipe advances together
// whenever the response register is empty or being taken, so backpressure
// holds every request in place and nothing is dropped.
// Beta (csr_beta_coefficient) is sampled when a request is accepted and rides
// with it; csr writes are always taken. Code 1023 gives -273 with
// range_error, and results above 1023 saturate to 1023 with range_error.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_adc_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [10:0] rsp_temp_celsius,
   output logic               rsp_range_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [12:0]        csr_beta_coefficient
);

   logic adv;

   // ---------------- configuration ----------------
   logic [12:0] beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= ntcbc_pkg::BETA_RESET;
      end else if (csr_valid) begin
         beta_ff <= csr_beta_coefficient;
      end
   end

   assign csr_ready = 1'b1;

   // ---------------- ratio divider: floor(1025*2^16 / a) ----------------
   ntcbc_pkg::tag_type tg_ff [0:27];
   logic [9:0]  dv_ff [0:27];
   logic [9:0]  rm_ff [0:27];
   logic [26:0] qt_ff [0:27];

   // beta/298 side computation, aligned with ratio stages 1..3
   logic [28:0] bp1_ff, bp2_ff;
   logic [19:0] by_ff;
   logic [11:0] bq_ff;
   logic [39:0] by_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         tg_ff[0].vld <= 1'b0;
      end else if (adv) begin
         tg_ff[0].vld  <= req_valid;
         tg_ff[0].zero <= (req_adc_code == ntcbc_pkg::CODE_FULL);
         tg_ff[0].beta <= beta_ff;
         tg_ff[0].b298 <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= ntcbc_pkg::CODE_FULL - req_adc_code;
         rm_ff[0] <= '0;
         qt_ff[0] <= '0;
      end
   end

   assign by_prod = 40'(by_ff) * 40'(ntcbc_pkg::B298_RECIP);

   always_ff @(posedge clock) begin
      if (adv) begin
         bp1_ff <= 29'(tg_ff[0].beta) * 29'(ntcbc_pkg::B298_INT);
         by_ff  <= 20'(tg_ff[0].beta) * 20'(ntcbc_pkg::B298_REM);
         bq_ff  <= by_prod[39:28];
         bp2_ff <= bp1_ff;
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < 27; k++) begin : g_rdiv
      logic [10:0]        trial;
      logic               ge;
      ntcbc_pkg::tag_type tg_in;
      always_comb begin
         trial = {rm_ff[k], ntcbc_pkg::RATIO_NUM[26-k]};
         ge    = (trial >= {1'b0, dv_ff[k]});
         tg_in = tg_ff[k];
         if (k == 2) begin
            tg_in.b298 = bp2_ff + 29'(bq_ff);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            tg_ff[k+1].vld <= 1'b0;
         end else if (adv) begin
            tg_ff[k+1] <= tg_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
            rm_ff[k+1] <= ge ? 10'(trial - {1'b0, dv_ff[k]}) : trial[9:0];
            qt_ff[k+1] <= {qt_ff[k][25:0], ge};
         end
      end
   end

   // ---------------- natural log of the ratio ----------------
   ntcbc_pkg::tag_type ln_tag;
   logic               ln_neg;
   logic [28:0]        ln_mag;

   ntcbc_ln_pipe u_ln (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .tag_in   (tg_ff[27]),
      .ratio_in (qt_ff[27] - ntcbc_pkg::RATIO_ONE),
      .tag_out  (ln_tag),
      .ln_neg   (ln_neg),
      .ln_mag   (ln_mag)
   );

   // ---------------- denominator D = ln(r) + beta/298 ----------------
   ntcbc_pkg::tag_type  dtg_ff;
   logic signed [30:0]  d_ff, d_in;

   always_comb begin
      d_in = $signed({2'b0, ln_tag.b298});
      if (ln_neg) begin
         d_in = d_in - $signed({2'b0, ln_mag});
      end else begin
         d_in = d_in + $signed({2'b0, ln_mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dtg_ff.vld <= 1'b0;
      end else if (adv) begin
         dtg_ff <= ln_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   // ---------------- quotient beta*2^34 / D, 21 bits ----------------
   // q >= 2^21 (beta*2^13 >= D) always saturates, so only 21 bits are built.
   ntcbc_pkg::tag_type qtg_ff [0:21];
   logic [29:0] qdv_ff  [0:21];
   logic [29:0] qrm_ff  [0:21];
   logic [20:0] qq_ff   [0:21];
   logic        qpos_ff [0:21];
   logic        qovf_ff [0:21];

   always_ff @(posedge clock) begin
      if (reset) begin
         qtg_ff[0].vld <= 1'b0;
      end else if (adv) begin
         qtg_ff[0] <= dtg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qdv_ff[0]  <= d_ff[29:0];
         qrm_ff[0]  <= {4'b0, dtg_ff.beta, 13'b0};
         qq_ff[0]   <= '0;
         qpos_ff[0] <= !d_ff[30] && (d_ff != '0);
         qovf_ff[0] <= ({4'b0, dtg_ff.beta, 13'b0} >= d_ff[29:0]);
      end
   end

   for (genvar k = 0; k < 21; k++) begin : g_qdiv
      logic [30:0] trial;
      logic        ge;
      always_comb begin
         trial = {qrm_ff[k], 1'b0};
         ge    = (trial >= {1'b0, qdv_ff[k]});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            qtg_ff[k+1].vld <= 1'b0;
         end else if (adv) begin
            qtg_ff[k+1] <= qtg_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            qdv_ff[k+1]  <= qdv_ff[k];
            qrm_ff[k+1]  <= ge ? 30'(trial - {1'b0, qdv_ff[k]}) : trial[29:0];
            qq_ff[k+1]   <= {qq_ff[k][19:0], ge};
            qpos_ff[k+1] <= qpos_ff[k];
            qovf_ff[k+1] <= qovf_ff[k];
         end
      end
   end

   // ---------------- Kelvin to Celsius, saturation ----------------
   logic signed [22:0] tq;
   logic               tneg;
   logic [22:0]        tmag;
   logic [12:0]        whole;
   logic signed [10:0] temp_in;
   logic               err_in;

   always_comb begin
      tq    = $signed({2'b0, qq_ff[21]}) - ntcbc_pkg::ZERO_C_Q10;
      tneg  = tq[22];
      tmag  = tneg ? (~tq + 23'd1) : tq;
      whole = tmag[22:10];
      if (qtg_ff[21].zero) begin
         temp_in = ntcbc_pkg::T_MIN;
         err_in  = 1'b1;
      end else if (!qpos_ff[21] || qovf_ff[21]) begin
         temp_in = ntcbc_pkg::T_MAX;
         err_in  = 1'b1;
      end else if (!tneg && (whole > ntcbc_pkg::T_MAX_MAG)) begin
         temp_in = ntcbc_pkg::T_MAX;
         err_in  = 1'b1;
      end else begin
         temp_in = tneg ? 11'(~whole + 13'd1) : whole[10:0];
         err_in  = 1'b0;
      end
   end

   // ---------------- response register ----------------
   logic               rv_ff;
   logic signed [10:0] rt_ff;
   logic               re_ff;

   assign adv = !rv_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= qtg_ff[21].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff <= temp_in;
         re_ff <= err_in;
      end
   end

   assign req_ready        = adv;
   assign rsp_valid        = rv_ff;
   assign rsp_temp_celsius = rt_ff;
   assign rsp_range_error  = re_ff;

endmodule

/* sv/ntcbc_checker.sv */
// ----------------------------------------------------------------------------
// NTC converter port checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "ntc_beta_temperature_converter_unit_defines.svh"

module ntcbc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [10:0] rsp_temp_celsius,
   input logic               rsp_range_error
);

   // stalled response holds
   `NTCBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_temp_celsius) && $stable(rsp_range_error), "response changed while stalled")

   // an empty output stage never blocks requests
   `NTCBC_ASSERT(a_ready_free, clock, reset, !rsp_valid, req_ready, "request blocked with empty output")

   // errors only carry a saturated value
   `NTCBC_ASSERT(a_err_sat, clock, reset, rsp_valid && rsp_range_error, (rsp_temp_celsius == 11'sd1023) || (rsp_temp_celsius == -11'sd273), "error without saturated temperature")

   // good results lie in range
   `NTCBC_ASSERT(a_ok_range, clock, reset, rsp_valid && !rsp_range_error, (rsp_temp_celsius >= -11'sd273) && (rsp_temp_celsius <= 11'sd1023), "temperature out of range without error")

endmodule

bind ntc_beta_temperature_converter_unit ntcbc_checker u_ntcbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_temp_celsius (rsp_temp_celsius),
   .rsp_range_error  (rsp_range_error)
);

/* test/ntc_beta_temperature_converter_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTC beta converter testbench
// Drives ADC codes through the converter under several beta settings, with
// random idling on both channels, and checks every response against an
// in-bench fixed-point model of the beta equation.
// ----------------------------------------------------------------------------

class temp_scoreboard;
   logic signed [10:0] temps_expected[$];
   logic               errs_expected[$];
   int                 mismatches;

   // fixed-point natural log of a Q16.16 ratio, result in Q8.24
   function automatic longint ln_q24(logic [31:0] r);
      int          p;
      logic [63:0] m, sq;
      longint      frac, lg, mag, ln;
      p = 0;
      for (int k = 0; k < 32; k++) if (r[k]) p = k;
      m = 64'(r) << (30 - p);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         sq = (m * m) >> 30;
         frac = frac << 1;
         if (sq >= 64'h8000_0000) begin
            frac = frac | 1;
            m = sq >> 1;
         end else begin
            m = sq;
         end
      end
      lg = longint'(p - 16) * 16777216 + frac;
      mag = (lg < 0) ? -lg : lg;
      ln = longint'((64'(mag) * 64'hB17217F8) >> 32);
      return (lg < 0) ? -ln : ln;
   endfunction

   function void note_request(logic [9:0] code, logic [12:0] beta);
      logic [31:0] a, r;
      longint      d, q, tq, t;
      logic        err;
      a = 32'd1023 - code;
      err = 0;
      if (a == 0) begin
         t = -273;
         err = 1;
      end else begin
         r = 32'((64'd1025 << 16) / a) - 32'd65536;
         d = ln_q24(r) + longint'((64'(beta) << 24) / 298);
         if (d <= 0) begin
            t = 1023;
            err = 1;
         end else begin
            q = longint'((64'(beta) << 34) / 64'(d));
            tq = q - 273 * 1024;
            t = (tq >= 0) ? (tq >>> 10) : -((-tq) >>> 10);
            if (t > 1023) begin
               t = 1023;
               err = 1;
            end else if (t < -273) begin
               t = -273;
            end
         end
      end
      temps_expected.push_back(11'(t));
      errs_expected.push_back(err);
   endfunction

   task report(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   task check_response(logic signed [10:0] temp, logic err);
      logic signed [10:0] et;
      logic               ee;
      if (temps_expected.size() == 0) begin
         report($sformatf("unexpected response temp=%0d err=%0b", temp, err));
         return;
      end
      et = temps_expected.pop_front();
      ee = errs_expected.pop_front();
      if (temp !== et) report($sformatf("temp %0d, expected %0d", temp, et));
      if (err !== ee) report($sformatf("range_error %0b, expected %0b", err, ee));
   endtask
endclass

module ntc_beta_temperature_converter_unit_test;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [9:0]         req_adc_code;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [10:0] rsp_temp_celsius;
   logic               rsp_range_error;
   logic               csr_valid;
   logic               csr_ready;
   logic [12:0]        csr_beta_coefficient;

   temp_scoreboard temps = new();
   logic [12:0]    beta_now = 13'd3950;   // beta the next request will carry
   int             send_idle_pct, take_idle_pct;
   int             quiet_cycles;
   bit             timed_out;

   localparam int WATCHDOG_LIMIT = 5000;

   ntc_beta_temperature_converter_unit DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // response side: random stall, check each accepted response
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            temps.check_response(rsp_temp_celsius, rsp_range_error);
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // valid stays up between back-to-back requests; callers drop it when done
   task automatic send_request(logic [9:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid    <= 1;
      req_adc_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      temps.note_request(code, beta_now);
   endtask

   // only while idle: drain, then a pause for the pipeline depth
   task automatic write_beta(logic [12:0] beta);
      req_valid <= 0;
      while (temps.temps_expected.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid            <= 1;
      csr_beta_coefficient <= beta;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      beta_now = beta;
   endtask

   task automatic random_phase(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(9);
         if (roll == 0) send_request(10'($urandom_range(1023, 1000)));
         else if (roll == 1) send_request(10'($urandom_range(30)));
         else send_request(10'($urandom));
      end
   endtask

   initial begin
      logic [12:0] betas[6];
      betas = '{13'd2500, 13'd6000, 13'd8191, 13'd0, 13'd4321, 13'd3950};
      reset = 1;
      req_valid = 0;
      req_adc_code = 0;
      csr_valid = 0;
      csr_beta_coefficient = 0;
      send_idle_pct = 10;
      take_idle_pct = 69;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, code 1023, hot and cold ends, under reset beta
      foreach (betas[k]) begin
         if (k == 2) begin
            send_idle_pct = 69;
            take_idle_pct = 10;
         end else if (k == 4) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         if (k == 0) begin
            send_request(10'd0);
            send_request(10'd1023);
            send_request(10'd1022);
            send_request(10'd1);
            send_request(10'd512);
            send_request(10'h155);
            send_request(10'h2AA);
         end
         write_beta(betas[k]);
         send_request(10'd1023);
         send_request(10'd0);
         send_request(10'd1020);
         random_phase(k >= 4 ? 200 : 100);
      end

      req_valid <= 0;
      while (temps.temps_expected.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (temps.mismatches == 0 && temps.temps_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
